/* src/apfr_pkg.sv */
// Shared types, constants and reply byte table for the frame responder.
package apfr_pkg;

  // Descriptor and packet layout
  localparam int unsigned DESC_BYTES  = 20;
  localparam int unsigned HEAD_BYTES  = 10;
  localparam int unsigned MAX_FRAME_LOG2_DEF = 24;

  localparam logic [31:0] CTRL_CHANNEL = 32'hFFFF_FFFF;
  localparam logic [7:0]  TAG_WORD     = 8'h4C;
  localparam logic [31:0] CMD_REPLY    = 32'd2;
  localparam logic [31:0] CMD_AUTH     = 32'd8;
  localparam logic [31:0] CMD_SET_NAME = 32'd9;
  localparam logic [31:0] CMD_SUBSCRIBE = 32'd35;

  // Reply lengths in bytes, descriptor included
  localparam logic [5:0] REPLY_LONG_BYTES  = 6'd35;
  localparam logic [5:0] REPLY_SHORT_BYTES = 6'd30;

  // Configuration register defaults
  localparam logic [24:0] MAX_FRAME_LEN_RST  = 25'd16777216;
  localparam logic [31:0] SERVER_VERSION_RST = 32'd34;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // Output request packing
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned OUT_TUSER_W = 2;

  typedef enum logic [0:0] {
    REG_MAX_FRAME_LEN  = 1'b0,
    REG_SERVER_VERSION = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    KIND_REPLY = 2'd0,
    KIND_BLOCK = 2'd1,
    KIND_ERROR = 2'd2
  } out_kind_t;

  typedef enum logic [2:0] {
    ERR_SHM_FLAGS   = 3'd0,
    ERR_BAD_LENGTH  = 3'd1,
    ERR_PKT_FLAGS   = 3'd2,
    ERR_MALFORMED   = 3'd3,
    ERR_UNSUPPORTED = 3'd4
  } err_code_t;

  typedef enum logic [1:0] {
    SEL_AUTH      = 2'd0,
    SEL_SET_NAME  = 2'd1,
    SEL_SUBSCRIBE = 2'd2
  } reply_sel_t;

  // One unit of work handed from front to back
  typedef struct packed {
    out_kind_t   kind;
    err_code_t   err;
    reply_sel_t  sel;
    logic [31:0] tag;
    logic [24:0] length;
    logic [31:0] channel;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // Byte idx of a reply frame
  function automatic logic [7:0] reply_byte_f(input logic [5:0] idx,
                                              input reply_sel_t sel,
                                              input logic [31:0] tag,
                                              input logic [31:0] version);
    logic [31:0] word3;
    logic [7:0]  plen;
    logic [7:0]  res;
    word3 = (sel == SEL_AUTH) ? version : 32'd0;
    plen  = (sel == SEL_SUBSCRIBE) ? 8'd10 : 8'd15;
    unique case (idx)
      6'd3:                       res = plen;
      6'd4, 6'd5, 6'd6, 6'd7:     res = 8'hFF;
      6'd20, 6'd25, 6'd30:        res = TAG_WORD;
      6'd24:                      res = CMD_REPLY[7:0];
      6'd26:                      res = tag[31:24];
      6'd27:                      res = tag[23:16];
      6'd28:                      res = tag[15:8];
      6'd29:                      res = tag[7:0];
      6'd31:                      res = word3[31:24];
      6'd32:                      res = word3[23:16];
      6'd33:                      res = word3[15:8];
      6'd34:                      res = word3[7:0];
      default:                    res = 8'd0;
    endcase
    return res;
  endfunction

endpackage

/* src/apfr_front.sv */
// Front end: descriptor assembly, frame checks and packet header decode.
module apfr_front
  import apfr_pkg::*;
#(
  parameter int unsigned MAX_FRAME_LOG2 = MAX_FRAME_LOG2_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic [24:0] max_frame_len,
  input  queue_stat_t qstat,
  output logic        push,
  output job_t        push_job
);

  localparam int unsigned PW = MAX_FRAME_LOG2;
  localparam logic [24:0] LIMIT_CAP = 25'(1) << MAX_FRAME_LOG2;

  logic [4:0]    desc_cnt;
  logic          in_payload;
  logic [PW-1:0] pay_cnt;
  logic [31:0]   frame_length;
  logic [31:0]   frame_channel;
  logic [31:0]   frame_flags;
  logic          is_memory_block;
  logic [7:0]    packet_head [HEAD_BYTES];
  logic          closed;

  logic          accept;
  logic [31:0]   flags_next;
  logic [24:0]   limit;
  logic          head_wr;
  logic [7:0]    head_view [HEAD_BYTES];
  logic [31:0]   cmd;
  logic [31:0]   tag;
  logic          frame_end;

  assign in_ready = closed || !qstat.full;
  assign accept   = in_valid && in_ready && !closed;

  assign flags_next = {frame_flags[23:0], rx_byte};
  assign limit      = (max_frame_len < LIMIT_CAP) ? max_frame_len : LIMIT_CAP;
  assign head_wr    = in_payload && !is_memory_block &&
                      (pay_cnt < PW'(HEAD_BYTES));
  assign frame_end  = in_payload && ({1'b0, pay_cnt} + (PW+1)'(1) ==
                      frame_length[PW:0]);

  // Header as seen including the byte arriving now
  always_comb begin
    for (int k = 0; k < HEAD_BYTES; k++) begin
      head_view[k] = (head_wr && pay_cnt == PW'(k)) ? rx_byte : packet_head[k];
    end
    cmd = {head_view[1], head_view[2], head_view[3], head_view[4]};
    tag = {head_view[6], head_view[7], head_view[8], head_view[9]};
  end

  // Job classification for the current byte
  always_comb begin
    push              = 1'b0;
    push_job          = '0;
    push_job.kind     = KIND_ERROR;
    push_job.err      = ERR_SHM_FLAGS;
    push_job.sel      = SEL_AUTH;
    push_job.tag      = tag;
    push_job.length   = frame_length[24:0];
    push_job.channel  = frame_channel;
    if (accept && !in_payload && desc_cnt == 5'(DESC_BYTES - 1)) begin
      if (flags_next[31:24] != 8'd0) begin
        push         = 1'b1;
        push_job.err = ERR_SHM_FLAGS;
      end else if (frame_length == 32'd0 || frame_length > {7'd0, limit}) begin
        push         = 1'b1;
        push_job.err = ERR_BAD_LENGTH;
      end else if (frame_channel == CTRL_CHANNEL && flags_next != 32'd0) begin
        push         = 1'b1;
        push_job.err = ERR_PKT_FLAGS;
      end
    end else if (accept && frame_end) begin
      push = 1'b1;
      if (is_memory_block) begin
        push_job.kind = KIND_BLOCK;
      end else if (frame_length < 32'd5 || head_view[0] != TAG_WORD ||
                   frame_length < 32'(HEAD_BYTES) || head_view[5] != TAG_WORD) begin
        push_job.err = ERR_MALFORMED;
      end else if (cmd == CMD_AUTH) begin
        push_job.kind = KIND_REPLY;
        push_job.sel  = SEL_AUTH;
      end else if (cmd == CMD_SET_NAME) begin
        push_job.kind = KIND_REPLY;
        push_job.sel  = SEL_SET_NAME;
      end else if (cmd == CMD_SUBSCRIBE) begin
        push_job.kind = KIND_REPLY;
        push_job.sel  = SEL_SUBSCRIBE;
      end else begin
        push_job.err = ERR_UNSUPPORTED;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      desc_cnt        <= '0;
      in_payload      <= 1'b0;
      pay_cnt         <= '0;
      is_memory_block <= 1'b0;
      closed          <= 1'b0;
    end else if (accept) begin
      if (push && push_job.kind == KIND_ERROR) begin
        closed <= 1'b1;
      end
      if (!in_payload) begin
        if (desc_cnt == 5'(DESC_BYTES - 1)) begin
          desc_cnt        <= '0;
          in_payload      <= 1'b1;
          pay_cnt         <= '0;
          is_memory_block <= (frame_channel != CTRL_CHANNEL);
        end else begin
          desc_cnt <= desc_cnt + 5'd1;
        end
      end else if (frame_end) begin
        in_payload <= 1'b0;
      end else begin
        pay_cnt <= pay_cnt + PW'(1);
      end
    end
  end

  // Descriptor words and packet header bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length  <= '0;
      frame_channel <= '0;
      frame_flags   <= '0;
    end else if (accept && !in_payload) begin
      if (desc_cnt < 5'd4) begin
        frame_length <= {frame_length[23:0], rx_byte};
      end else if (desc_cnt < 5'd8) begin
        frame_channel <= {frame_channel[23:0], rx_byte};
      end else if (desc_cnt >= 5'd16) begin
        frame_flags <= flags_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && head_wr) begin
      for (int k = 0; k < HEAD_BYTES; k++) begin
        if (pay_cnt == PW'(k)) begin
          packet_head[k] <= rx_byte;
        end
      end
    end
  end

endmodule

/* src/apfr_queue.sv */
// Short job queue between the front and back ends.
module apfr_queue
  import apfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  job_t        push_job,
  input  logic        pop,
  output job_t        head_job,
  output queue_stat_t qstat
);

  job_t                entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;
  logic                do_push;
  logic                do_pop;

  assign qstat.full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head_job    = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

/* src/apfr_back.sv */
// Back end: expands queued jobs into output requests through a register.
module apfr_back
  import apfr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  job_t                   head_job,
  input  queue_stat_t            qstat,
  output logic                   pop,
  input  logic [31:0]            server_version,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic [OUT_TUSER_W-1:0] m_tuser,
  output logic                   m_tlast
);

  logic [5:0]             idx;
  logic                   load;
  logic [5:0]             total;
  logic                   job_last;
  logic [7:0]             rbyte;
  logic [OUT_TDATA_W-1:0] tdata_next;
  logic                   tlast_next;

  assign load     = !qstat.empty && (!m_tvalid || m_tready);
  assign total    = (head_job.sel == SEL_SUBSCRIBE) ? REPLY_SHORT_BYTES
                                                    : REPLY_LONG_BYTES;
  assign job_last = (head_job.kind != KIND_REPLY) || (idx == total - 6'd1);
  assign pop      = load && job_last;
  assign rbyte    = reply_byte_f(idx, head_job.sel, head_job.tag, server_version);

  // Byte counter within the current reply
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load) begin
      idx <= job_last ? 6'd0 : idx + 6'd1;
    end
  end

  // Output request fields for the head job
  always_comb begin
    tdata_next = '0;
    tlast_next = 1'b0;
    unique case (head_job.kind)
      KIND_REPLY: begin
        tdata_next[7:0] = rbyte;
        tlast_next      = job_last;
      end
      KIND_BLOCK: begin
        tdata_next[35:11] = head_job.length;
        tdata_next[67:36] = head_job.channel;
      end
      default: begin
        tdata_next[10:8] = head_job.err;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tuser <= head_job.kind;
      m_tdata <= tdata_next;
      m_tlast <= tlast_next;
    end
  end

endmodule

/* src/audio_protocol_frame_responder.sv */
// Top level of the stream frame responder: configuration registers and wiring.
//
// Input channel s_*: one client stream byte per request in s_tdata. Each
// frame is a 20-byte big-endian descriptor (length, channel, two offsets,
// flags) followed by length payload bytes.
// Output channel m_*: tuser carries the kind (reply byte, memory block
// notice, fatal error); tlast marks the final byte of a reply frame.
// Configuration channel cfg_*: cfg_index 0 sets the largest payload length,
// 1 sets the version word given in the auth reply; always ready.
// Throughput: one input byte per cycle while the job queue has room. A
// reply produces 30 or 35 output requests, one per cycle while the receiver
// accepts them; the two-entry job queue absorbs the bytes of following frames
// until it fills, after which s_tready drops.
// A result for the byte that causes it reaches m_* through the queue write and
// then the output register.
// Reset clears all control state and loads the register defaults. After an
// error the block reports it once, then accepts and drops every byte.
// When the receiver stalls the output register holds, the queue fills and
// the input side is held off.
module audio_protocol_frame_responder
  import apfr_pkg::*;
#(
  parameter int unsigned MAX_FRAME_LOG2 = MAX_FRAME_LOG2_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // Input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // [7:0] rx_byte
  // Output stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [7:0] reply_byte, [10:8] error_code,
                                            // [35:11] block_length,
                                            // [67:36] block_channel, [71:68] zero
  output logic [OUT_TUSER_W-1:0] m_tuser,   // [1:0] out_kind
  output logic                   m_tlast,   // last_of_run
  // Configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [0:0]             cfg_index,
  input  logic [31:0]            cfg_data
);

  logic [24:0] max_frame_len;
  logic [31:0] server_version;
  logic        push;
  job_t        push_job;
  job_t        head_job;
  logic        pop;
  queue_stat_t qstat;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_len  <= MAX_FRAME_LEN_RST;
      server_version <= SERVER_VERSION_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_MAX_FRAME_LEN:  max_frame_len  <= cfg_data[24:0];
        REG_SERVER_VERSION: server_version <= cfg_data;
        default:            ;
      endcase
    end
  end

  apfr_front #(
    .MAX_FRAME_LOG2(MAX_FRAME_LOG2)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .rx_byte      (s_tdata),
    .max_frame_len(max_frame_len),
    .qstat        (qstat),
    .push         (push),
    .push_job     (push_job)
  );

  apfr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .head_job(head_job),
    .qstat   (qstat)
  );

  apfr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_job      (head_job),
    .qstat         (qstat),
    .pop           (pop),
    .server_version(server_version),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast)
  );

endmodule
